[rtl/modbus_rtu_response_checker_macros.svh]
// Assertion macros for the Modbus RTU response checker.
// Included by files that carry concurrent assertions; needs no package.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

`define MRRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define MRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MRRC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define MRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/mrrc_pkg.sv]
// Types and constants for the Modbus RTU response checker.
// No dependencies; used by mrrc_crc_byte and the top level.
package mrrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] MAX_DATA_RESET = 8'd16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] node_addr;
    logic [7:0] func_byte;
    logic [7:0] data_length;
  } out_t;

endpackage

[rtl/mrrc_crc_byte.sv]
// Byte-wide CRC-16/MODBUS update, eight reflected shift steps unrolled.
// Depends on mrrc_pkg for the polynomial.
module mrrc_crc_byte import mrrc_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[rtl/modbus_rtu_response_checker.sv]
// Modbus RTU response checker: frame parse, byte count limit and CRC-16 check.
// The byte that ends the frame passes the byte register, then the result
// register, which raises out_valid with its verdict.
// Throughput: one byte per cycle; the byte register waits only while the result
// register is full and out_stall is high.
// Reset (rst_n low, synchronous): idle, no result held, limit back to 16.
// Depends on mrrc_pkg, mrrc_crc_byte and the assertion macro header.
`include "modbus_rtu_response_checker_macros.svh"

module modbus_rtu_response_checker import mrrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FUNC   = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CRC_LO = 3'd4;
  localparam logic [2:0] PH_CRC_HI = 3'd5;

  logic        in_valid_r;
  in_t         in_q_r;
  logic        out_valid_r;
  out_t        out_data_r;
  logic [7:0]  max_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic        out_blocked;
  logic        fire;
  logic        emit;
  logic [1:0]  emit_status;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic [15:0] crc_got;

  assign out_blocked = out_valid_r && out_stall;
  assign fire        = in_valid_r && !out_blocked;
  assign in_stall    = in_valid_r && out_blocked;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  assign crc_base = in_q_r.frame_start ? CRC_INIT : crc_r;
  assign crc_got  = {in_q_r.rx_byte, crc_lo_r};

  mrrc_crc_byte u_crc (
    .crc_in  (crc_base),
    .data_in (in_q_r.rx_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    left_nxt    = left_r;
    addr_nxt    = addr_r;
    func_nxt    = func_r;
    len_nxt     = len_r;
    crc_lo_nxt  = crc_lo_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    if (in_q_r.frame_start) begin
      addr_nxt   = in_q_r.rx_byte;
      func_nxt   = 8'd0;
      len_nxt    = 8'd0;
      left_nxt   = 8'd0;
      crc_lo_nxt = 8'd0;
      crc_nxt    = crc_upd;
      phase_nxt  = PH_FUNC;
    end else begin
      unique case (phase_r)
        PH_FUNC: begin
          func_nxt  = in_q_r.rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          len_nxt = in_q_r.rx_byte;
          crc_nxt = crc_upd;
          if (in_q_r.rx_byte > max_r) begin
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_status = ST_OVERFLOW;
          end else begin
            left_nxt  = in_q_r.rx_byte;
            phase_nxt = (in_q_r.rx_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt  = crc_upd;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = in_q_r.rx_byte;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          phase_nxt   = PH_IDLE;
          emit        = 1'b1;
          emit_status = (crc_got == crc_r) ? ST_OK : ST_CRC_ERR;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // byte register: hold a waiting byte while the result register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_q_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      crc_r    <= CRC_INIT;
      left_r   <= 8'd0;
      addr_r   <= 8'd0;
      func_r   <= 8'd0;
      len_r    <= 8'd0;
      crc_lo_r <= 8'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      left_r   <= left_nxt;
      addr_r   <= addr_nxt;
      func_r   <= func_nxt;
      len_r    <= len_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_DATA_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  // result register: load on a finished frame, drop once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_blocked) begin
      out_valid_r <= fire && emit;
    end
    if (fire && emit) begin
      out_data_r.status      <= emit_status;
      out_data_r.node_addr   <= addr_nxt;
      out_data_r.func_byte   <= func_nxt;
      out_data_r.data_length <= len_nxt;
    end
  end

  `MRRC_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, in_valid_r && out_valid_r && out_stall)
  `MRRC_ASSERT_SAME(a_emit_phase, clk, rst_n, fire && emit, !in_q_r.frame_start && (phase_r == PH_COUNT || phase_r == PH_CRC_HI))
  `MRRC_ASSERT_SAME(a_data_left, clk, rst_n, fire && !in_q_r.frame_start && phase_r == PH_DATA, left_r != 8'd0)
  `MRRC_ASSERT_NEXT(a_result_kept, clk, rst_n, out_valid_r && out_stall, out_valid_r && $stable(out_data_r))

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for modbus_rtu_response_checker: frame bytes in, verdicts out.
// Predicts each verdict with its own frame tracker and CRC-16; depends on mrrc_pkg and the DUT module.
module testbench import mrrc_pkg::*; ();

  typedef enum logic [2:0] {
    PH_IDLE, PH_FUNC, PH_COUNT, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } frame_phase_t;

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_TRUNC, FR_OVER} frame_kind_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // frame tracker state
  logic [7:0]   limit_q = MAX_DATA_RESET;
  frame_phase_t phase_q = PH_IDLE;
  logic [15:0]  crc_q   = CRC_INIT;
  logic [7:0]   left_q  = '0;
  logic [7:0]   addr_q  = '0;
  logic [7:0]   func_q  = '0;
  logic [7:0]   len_q   = '0;
  logic [7:0]   lo_q    = '0;

  out_t verdicts_q[$];
  in_t  tx_bytes[$];
  int   mismatches  = 0;
  int   frame_items = 0;
  int   hold_req    = 0;
  bit   gaps_on     = 1'b1;
  bit   stalls_on   = 1'b1;

  modbus_rtu_response_checker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void push_verdict(logic [1:0] status);
    out_t v;
    v.status      = status;
    v.node_addr   = addr_q;
    v.func_byte   = func_q;
    v.data_length = len_q;
    verdicts_q.push_back(v);
  endfunction

  function automatic void track_frame_byte(in_t it);
    logic [7:0]  b;
    logic [15:0] got;
    b = it.rx_byte;
    if (it.frame_start) begin
      addr_q  = b;
      func_q  = '0;
      len_q   = '0;
      left_q  = '0;
      lo_q    = '0;
      crc_q   = crc16_feed(CRC_INIT, b);
      phase_q = PH_FUNC;
    end else begin
      case (phase_q)
        PH_FUNC: begin
          func_q  = b;
          crc_q   = crc16_feed(crc_q, b);
          phase_q = PH_COUNT;
        end
        PH_COUNT: begin
          len_q = b;
          crc_q = crc16_feed(crc_q, b);
          if (b > limit_q) begin
            phase_q = PH_IDLE;
            push_verdict(ST_OVERFLOW);
          end else begin
            left_q  = b;
            phase_q = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_q  = crc16_feed(crc_q, b);
          left_q = left_q - 8'd1;
          if (left_q == 8'd0) phase_q = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          lo_q    = b;
          phase_q = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          got     = {b, lo_q};
          phase_q = PH_IDLE;
          push_verdict((got == crc_q) ? ST_OK : ST_CRC_ERR);
        end
        default: begin
          phase_q = PH_IDLE;
        end
      endcase
    end
  endfunction

  function automatic in_t mk_item(logic [7:0] b, logic s);
    in_t it;
    it.rx_byte     = b;
    it.frame_start = s;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void add_frame(logic [7:0] addr, logic [7:0] func, logic [7:0] cnt,
                                    frame_kind_t kind);
    in_t         fb[$];
    logic [15:0] crc;
    logic [7:0]  d;
    int          keep;
    crc = crc16_feed(CRC_INIT, addr);
    fb.push_back(mk_item(addr, 1'b1));
    fb.push_back(mk_item(func, 1'b0));
    crc = crc16_feed(crc, func);
    fb.push_back(mk_item(cnt, 1'b0));
    crc = crc16_feed(crc, cnt);
    if (kind == FR_OVER) begin
      // trailing bytes must be dropped until the next start
      repeat ($urandom_range(1, 3)) fb.push_back(mk_item(8'($urandom()), 1'b0));
    end else begin
      for (int i = 0; i < cnt; i++) begin
        d = 8'($urandom());
        fb.push_back(mk_item(d, 1'b0));
        crc = crc16_feed(crc, d);
      end
      if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(1, 16'hFFFF));
      fb.push_back(mk_item(crc[7:0], 1'b0));
      fb.push_back(mk_item(crc[15:8], 1'b0));
      if (kind == FR_TRUNC) begin
        keep = $urandom_range(1, fb.size() - 1);
        while (fb.size() > keep) void'(fb.pop_back());
      end
    end
    frame_items += fb.size();
    tx_bytes = {tx_bytes, fb};
  endfunction

  task automatic send_item(in_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_frame_byte(it);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic flush_bytes();
    while (tx_bytes.size() > 0) send_item(tx_bytes.pop_front());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk);
    // let bytes that yield no verdict clear the pipeline
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    limit_q = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    tx_bytes.push_back(mk_item(8'hFF, 1'b0));
    add_frame(8'h00, 8'hFF, 8'd0, FR_GOOD);
    add_frame(8'hFF, 8'h00, 8'd0, FR_BAD_CRC);
    add_frame(8'h11, 8'h83, 8'd17, FR_OVER);
    add_frame(8'h22, 8'h03, 8'd0, FR_TRUNC);
    add_frame(8'h5A, 8'hA5, 8'd1, FR_GOOD);
    flush_bytes();
    drain_results();
  endtask

  task automatic test_limit_extremes();
    write_limit(8'd0);
    add_frame(8'($urandom()), 8'($urandom()), 8'd0, FR_GOOD);
    add_frame(8'($urandom()), 8'($urandom()), 8'd1, FR_OVER);
    flush_bytes();
    write_limit(8'hFF);
    add_frame(8'($urandom()), 8'($urandom()), 8'hFF, FR_GOOD);
    flush_bytes();
    write_limit(MAX_DATA_RESET);
    add_frame(8'($urandom()), 8'($urandom()), 8'd16, FR_GOOD);
    add_frame(8'($urandom()), 8'($urandom()), 8'd17, FR_OVER);
    flush_bytes();
    drain_results();
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 400;
    repeat (10) begin
      add_frame(8'($urandom()), 8'($urandom()), 8'($urandom_range(0, 3)),
                ($urandom_range(0, 1) == 0) ? FR_GOOD : FR_BAD_CRC);
    end
    flush_bytes();
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int          lim;
    int          cnt;
    int          top;
    int          r;
    int          goal;
    frame_kind_t kind;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lim = 0;
        1: lim = 255;
        2: lim = 1;
        default: lim = $urandom_range(2, 24);
      endcase
      write_limit(8'(lim));
      gaps_on   = (ph != 4);
      stalls_on = (ph != 4);
      goal = frame_items + 90;
      while (frame_items < goal) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          repeat ($urandom_range(1, 3)) tx_bytes.push_back(mk_item(8'($urandom()), 1'b0));
        end else begin
          kind = (r < 60) ? FR_GOOD : (r < 75) ? FR_BAD_CRC : (r < 88) ? FR_TRUNC : FR_OVER;
          if (kind == FR_OVER && lim == 255) kind = FR_GOOD;
          if (kind == FR_OVER) begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(lim + 1, 255) : lim + 1;
          end else begin
            top = (lim > 10) ? 10 : lim;
            if ($urandom_range(0, 49) == 0) top = lim;
            cnt = $urandom_range(0, top);
          end
          add_frame(8'($urandom()), 8'($urandom()), 8'(cnt), kind);
        end
        flush_bytes();
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // receiver: random stall runs, plus a long hold-off on request
  initial begin
    int run_left;
    int hold_left;
    bit stall_now;
    run_left  = 0;
    hold_left = 0;
    stall_now = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (!stalls_on) begin
        stall_now = 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          run_left  = pick_gap() + 1;
        end
        run_left--;
      end
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict transfer: %p", out_data);
      end else begin
        want = verdicts_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.node_addr !== want.node_addr ||
            out_data.func_byte !== want.func_byte ||
            out_data.data_length !== want.data_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("verdict mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limit_extremes();
    test_backpressure();
    test_random_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && verdicts_q.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdicts_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
